### design/iir_direct_form_z2_filter_macros.svh
// ----------------------------------------------------------------------------
// iir direct form z2 filter assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef IIR_DIRECT_FORM_Z2_FILTER_MACROS_SVH
`define IIR_DIRECT_FORM_Z2_FILTER_MACROS_SVH

// same-cycle implication
`define DFZ2_ASSERT_SAME(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("iir filter check failed");

// next-cycle implication
`define DFZ2_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("iir filter check failed");

`endif

### design/iir_dfz2_pkg.sv
// ----------------------------------------------------------------------------
// iir_dfz2_pkg
// shared widths, command codes and control structs of the z2 iir filter
// ----------------------------------------------------------------------------
`default_nettype none

package iir_dfz2_pkg;

  localparam int COEF_W   = 24;  // signed q3.20 coefficient
  localparam int HIST_W   = 32;  // saturated history entry
  localparam int ACC_W    = 64;  // product accumulator
  localparam int PROD_W   = HIST_W + COEF_W;
  localparam int CMD_W    = 2;
  localparam int CIDX_W   = 5;   // coef_index port width
  localparam int TCREG_W  = 5;   // tap_count register field
  localparam int PDATA_W  = 32;
  localparam int PADDR_W  = 3;

  localparam logic [CMD_W-1:0] CMD_FILTER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_FB  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WR_FF  = 2'd2;

  localparam logic REG_TAP_COUNT = 1'b0;

  typedef struct packed {
    logic init;     // load x into feedback acc, clear feedforward acc
    logic tap_mul;  // multiply history entry by a and b
    logic w_mul;    // multiply w by b0
  } mac_ctrl_t;

  typedef struct packed {
    logic a_en;
    logic b0_en;
    logic bh_en;
  } coef_wr_t;

endpackage

`default_nettype wire

### design/iir_dfz2_hist_mem.sv
// ----------------------------------------------------------------------------
// iir_dfz2_hist_mem
// history memory, one write and one registered read port, read-first
// ----------------------------------------------------------------------------
`default_nettype none

module iir_dfz2_hist_mem #(
  parameter int DEPTH  = 32,
  parameter int AW     = 5,
  parameter int DATA_W = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  written;

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= written[rd_addr] ? mem[rd_addr] : '0;
  end

endmodule

`default_nettype wire

### design/iir_dfz2_coef_bank.sv
// ----------------------------------------------------------------------------
// iir_dfz2_coef_bank
// feedback and feedforward coefficient tables with registered tap read
// ----------------------------------------------------------------------------
`default_nettype none

module iir_dfz2_coef_bank #(
  parameter int MAX_TAPS = 16,
  parameter int CI_W     = 4
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire iir_dfz2_pkg::coef_wr_t                wr,
  input  wire logic [CI_W-1:0]                       a_idx,
  input  wire logic [CI_W-1:0]                       bh_idx,
  input  wire logic signed [iir_dfz2_pkg::COEF_W-1:0] wr_data,
  input  wire logic [CI_W-1:0]                       rd_idx,
  output logic signed [iir_dfz2_pkg::COEF_W-1:0]     a_rd,
  output logic signed [iir_dfz2_pkg::COEF_W-1:0]     bh_rd,
  output logic signed [iir_dfz2_pkg::COEF_W-1:0]     b0
);

  // bh[i] holds feedforward coefficient i+1
  logic signed [iir_dfz2_pkg::COEF_W-1:0] a  [MAX_TAPS];
  logic signed [iir_dfz2_pkg::COEF_W-1:0] bh [MAX_TAPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        a[i]  <= '0;
        bh[i] <= '0;
      end
      b0 <= '0;
    end else begin
      if (wr.a_en) begin
        a[a_idx] <= wr_data;
      end
      if (wr.bh_en) begin
        bh[bh_idx] <= wr_data;
      end
      if (wr.b0_en) begin
        b0 <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_rd  <= a[rd_idx];
    bh_rd <= bh[rd_idx];
  end

endmodule

`default_nettype wire

### design/iir_dfz2_mac.sv
// ----------------------------------------------------------------------------
// iir_dfz2_mac
// registered multipliers and the feedback / feedforward accumulators
// ----------------------------------------------------------------------------
`default_nettype none

module iir_dfz2_mac #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 20
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire iir_dfz2_pkg::mac_ctrl_t                ctrl,
  input  wire logic signed [SAMPLE_BITS-1:0]          x,
  input  wire logic signed [iir_dfz2_pkg::HIST_W-1:0] h,
  input  wire logic signed [iir_dfz2_pkg::HIST_W-1:0] w,
  input  wire logic signed [iir_dfz2_pkg::COEF_W-1:0] a,
  input  wire logic signed [iir_dfz2_pkg::COEF_W-1:0] bh,
  input  wire logic signed [iir_dfz2_pkg::COEF_W-1:0] b0,
  output logic signed [iir_dfz2_pkg::ACC_W-1:0]       acc_fb,
  output logic signed [iir_dfz2_pkg::ACC_W-1:0]       acc_ff
);

  localparam int PW = iir_dfz2_pkg::PROD_W;
  localparam int AW = iir_dfz2_pkg::ACC_W;

  logic signed [PW-1:0]                      prod_fb;
  logic signed [PW-1:0]                      prod_ff;
  logic                                      acc_en;
  logic signed [iir_dfz2_pkg::HIST_W-1:0]    mul_h;
  logic signed [iir_dfz2_pkg::COEF_W-1:0]    mul_c;
  logic signed [AW-1:0]                      x_scaled;

  assign mul_h    = ctrl.w_mul ? w : h;
  assign mul_c    = ctrl.w_mul ? b0 : bh;
  assign x_scaled = $signed({{(AW-SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x}) <<< COEF_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_en <= 1'b0;
    end else begin
      acc_en <= ctrl.tap_mul | ctrl.w_mul;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.tap_mul) begin
      prod_fb <= h * a;
    end else begin
      prod_fb <= '0;
    end
    prod_ff <= mul_h * mul_c;

    if (ctrl.init) begin
      acc_fb <= x_scaled;
      acc_ff <= '0;
    end else if (acc_en) begin
      acc_fb <= acc_fb - $signed({{(AW-PW){prod_fb[PW-1]}}, prod_fb});
      acc_ff <= acc_ff + $signed({{(AW-PW){prod_ff[PW-1]}}, prod_ff});
    end
  end

endmodule

`default_nettype wire

### design/iir_direct_form_z2_filter.sv
// ----------------------------------------------------------------------------
// iir_direct_form_z2_filter
// direct form ii iir filter in z^-2 with coefficient load words
// ----------------------------------------------------------------------------
// sample words: the input is stalled from accept until the result is loaded,
//   so a new sample word waits for the last; the pace is set by the history sweep
//   through the single read port of the history memory
// coefficient words give no result
// reset: synchronous, clears history, coefficients, and sets tap_count to 16 (or MAX_TAPS if smaller)
`default_nettype none

module iir_direct_form_z2_filter #(
  parameter int MAX_TAPS       = 16,
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 20
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  // configuration port
  input  wire logic                                       psel,
  input  wire logic                                       penable,
  input  wire logic                                       pwrite,
  input  wire logic [iir_dfz2_pkg::PADDR_W-1:0]           paddr,
  input  wire logic [iir_dfz2_pkg::PDATA_W-1:0]           pwdata,
  output logic      [iir_dfz2_pkg::PDATA_W-1:0]           prdata,
  output logic                                            pready,
  // input words
  input  wire logic                                       in_valid,
  output logic                                            in_stall,
  input  wire logic [iir_dfz2_pkg::CMD_W-1:0]             command,
  input  wire logic [iir_dfz2_pkg::CIDX_W-1:0]            coef_index,
  input  wire logic signed [iir_dfz2_pkg::COEF_W-1:0]     coef_value,
  input  wire logic signed [SAMPLE_BITS-1:0]              sample_in,
  // result words
  output logic                                            out_valid,
  input  wire logic                                       out_stall,
  output logic signed [SAMPLE_BITS-1:0]                   sample_out,
  output logic                                            clipped
);

  // widths derived from the tap count
  localparam int DEPTH  = 2 * MAX_TAPS;
  localparam int CI_W   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int IDX_W  = CI_W + 1;
  localparam int TC_W   = $clog2(MAX_TAPS + 1);
  localparam int SPAN_W = TC_W + 1;
  localparam int TCMP_W = (TC_W > iir_dfz2_pkg::TCREG_W) ? TC_W : iir_dfz2_pkg::TCREG_W;
  localparam int IX_W   = (CI_W + 1 > iir_dfz2_pkg::CIDX_W) ? CI_W + 1 : iir_dfz2_pkg::CIDX_W;
  localparam int TC_RST = (16 > MAX_TAPS) ? MAX_TAPS : 16;
  localparam int AW     = iir_dfz2_pkg::ACC_W;
  localparam int HW     = iir_dfz2_pkg::HIST_W;

  // rounding and saturation limits at accumulator width
  localparam logic signed [AW-1:0] HALF = AW'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [AW-1:0] W_HI = {{(AW-HW+1){1'b0}}, {(HW-1){1'b1}}};
  localparam logic signed [AW-1:0] W_LO = ~W_HI;
  localparam logic signed [AW-1:0] Y_HI = {{(AW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [AW-1:0] Y_LO = ~Y_HI;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,    // read every active history entry, shift it one place down
    ST_DRAIN1,   // last entry in the multipliers
    ST_DRAIN2,   // last products into the accumulators
    ST_ROUND_W,  // round and saturate w
    ST_W_MUL,    // b0 * w, store w at the head of the history
    ST_W_ACC,    // add b0 * w
    ST_OUT       // round and saturate y, hand it to the output register
  } state_t;

  state_t state;

  // ---------------------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------------------
  logic [TC_W-1:0]   tap_count;
  logic              cfg_wr;
  logic [TCMP_W-1:0] cfg_val;
  logic [TCMP_W-1:0] cfg_clamped;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & (paddr[2] == iir_dfz2_pkg::REG_TAP_COUNT);
  assign cfg_val = TCMP_W'(pwdata[iir_dfz2_pkg::TCREG_W-1:0]);

  // a write of zero gives one tap, anything above the maximum clamps to it
  always_comb begin
    priority if (cfg_val == '0) begin
      cfg_clamped = TCMP_W'(1);
    end else if (cfg_val > TCMP_W'(MAX_TAPS)) begin
      cfg_clamped = TCMP_W'(MAX_TAPS);
    end else begin
      cfg_clamped = cfg_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TC_W'(TC_RST);
    end else if (cfg_wr) begin
      tap_count <= cfg_clamped[TC_W-1:0];
    end
  end

  assign prdata = (paddr[2] == iir_dfz2_pkg::REG_TAP_COUNT) ?
                  iir_dfz2_pkg::PDATA_W'(tap_count) : '0;

  // ---------------------------------------------------------------------------
  // input word decode
  // ---------------------------------------------------------------------------
  logic                   in_accept;
  logic                   start;
  logic [IX_W-1:0]        cidx_ext;
  logic [IX_W-1:0]        cidx_m1;
  iir_dfz2_pkg::coef_wr_t coef_wr;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid & ~in_stall;
  assign start     = in_accept & (command == iir_dfz2_pkg::CMD_FILTER);
  assign cidx_ext  = IX_W'(coef_index);
  assign cidx_m1   = cidx_ext - IX_W'(1);

  // out-of-range slots are dropped
  always_comb begin
    coef_wr.a_en  = in_accept & (command == iir_dfz2_pkg::CMD_WR_FB) &
                    (cidx_ext < IX_W'(MAX_TAPS));
    coef_wr.b0_en = in_accept & (command == iir_dfz2_pkg::CMD_WR_FF) &
                    (cidx_ext == '0);
    coef_wr.bh_en = in_accept & (command == iir_dfz2_pkg::CMD_WR_FF) &
                    (cidx_ext != '0) & (cidx_ext <= IX_W'(MAX_TAPS));
  end

  // ---------------------------------------------------------------------------
  // sweep control and read pipeline
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0]  idx;        // history entry being read
  logic [SPAN_W-1:0] span_m1;
  logic [IDX_W-1:0]  last_idx;
  logic              s1_vld;     // read data valid this cycle
  logic [IDX_W-1:0]  s1_idx;
  logic              s1_last;

  assign span_m1  = {tap_count, 1'b0} - SPAN_W'(1);
  assign last_idx = span_m1[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= (state == ST_SWEEP);
    end
  end

  always_ff @(posedge clk) begin
    s1_idx  <= idx;
    s1_last <= (idx == last_idx);
  end

  // ---------------------------------------------------------------------------
  // history memory: the read of entry j is written back at j+1, w goes to 0
  // ---------------------------------------------------------------------------
  logic                 hist_we;
  logic [IDX_W-1:0]     hist_waddr;
  logic signed [HW-1:0] hist_wdata;
  logic signed [HW-1:0] hist_rd;
  logic signed [HW-1:0] w_reg;

  assign hist_we    = (s1_vld & ~s1_last) | (state == ST_W_MUL);
  assign hist_waddr = (state == ST_W_MUL) ? '0 : s1_idx + IDX_W'(1);
  assign hist_wdata = (state == ST_W_MUL) ? w_reg : hist_rd;

  iir_dfz2_hist_mem #(
    .DEPTH  (DEPTH),
    .AW     (IDX_W),
    .DATA_W (HW)
  ) u_hist (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (hist_we),
    .wr_addr (hist_waddr),
    .wr_data (hist_wdata),
    .rd_addr (idx),
    .rd_data (hist_rd)
  );

  // ---------------------------------------------------------------------------
  // coefficients, read in step with the history
  // ---------------------------------------------------------------------------
  logic signed [iir_dfz2_pkg::COEF_W-1:0] a_rd;
  logic signed [iir_dfz2_pkg::COEF_W-1:0] bh_rd;
  logic signed [iir_dfz2_pkg::COEF_W-1:0] b0;

  iir_dfz2_coef_bank #(
    .MAX_TAPS (MAX_TAPS),
    .CI_W     (CI_W)
  ) u_coef (
    .clk     (clk),
    .rst     (rst),
    .wr      (coef_wr),
    .a_idx   (cidx_ext[CI_W-1:0]),
    .bh_idx  (cidx_m1[CI_W-1:0]),
    .wr_data (coef_value),
    .rd_idx  (idx[IDX_W-1:1]),
    .a_rd    (a_rd),
    .bh_rd   (bh_rd),
    .b0      (b0)
  );

  // ---------------------------------------------------------------------------
  // multiply-accumulate; only odd history entries carry taps
  // ---------------------------------------------------------------------------
  iir_dfz2_pkg::mac_ctrl_t mac_ctrl;
  logic signed [AW-1:0]    acc_fb;
  logic signed [AW-1:0]    acc_ff;

  always_comb begin
    mac_ctrl.init    = start;
    mac_ctrl.tap_mul = s1_vld & s1_idx[0];
    mac_ctrl.w_mul   = (state == ST_W_MUL);
  end

  iir_dfz2_mac #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .x      (sample_in),
    .h      (hist_rd),
    .w      (w_reg),
    .a      (a_rd),
    .bh     (bh_rd),
    .b0     (b0),
    .acc_fb (acc_fb),
    .acc_ff (acc_ff)
  );

  // ---------------------------------------------------------------------------
  // rounding half up, then saturation
  // ---------------------------------------------------------------------------
  logic signed [AW-1:0] w_rnd;
  logic signed [AW-1:0] y_rnd;
  logic signed [AW-1:0] w_sat;
  logic signed [AW-1:0] y_sat;
  logic                 w_clip;
  logic                 y_clip;
  logic                 clip_w;   // w saturated, kept until the result

  assign w_rnd = (acc_fb + HALF) >>> COEF_FRAC_BITS;
  assign y_rnd = (acc_ff + HALF) >>> COEF_FRAC_BITS;

  always_comb begin
    priority if (w_rnd > W_HI) begin
      w_sat  = W_HI;
      w_clip = 1'b1;
    end else if (w_rnd < W_LO) begin
      w_sat  = W_LO;
      w_clip = 1'b1;
    end else begin
      w_sat  = w_rnd;
      w_clip = 1'b0;
    end
  end

  always_comb begin
    priority if (y_rnd > Y_HI) begin
      y_sat  = Y_HI;
      y_clip = 1'b1;
    end else if (y_rnd < Y_LO) begin
      y_sat  = Y_LO;
      y_clip = 1'b1;
    end else begin
      y_sat  = y_rnd;
      y_clip = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer and output register
  // ---------------------------------------------------------------------------
  logic out_free;

  assign out_free = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      // a taken word empties the register unless the next one loads now
      if (out_valid & ~out_stall & (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          idx <= '0;
          if (start) begin
            state <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          if (idx == last_idx) begin
            state <= ST_DRAIN1;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        ST_DRAIN1: begin
          state <= ST_DRAIN2;
        end
        ST_DRAIN2: begin
          state <= ST_ROUND_W;
        end
        ST_ROUND_W: begin
          w_reg  <= w_sat[HW-1:0];
          clip_w <= w_clip;
          state  <= ST_W_MUL;
        end
        ST_W_MUL: begin
          state <= ST_W_ACC;
        end
        ST_W_ACC: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          // wait here while the previous word is still held
          if (out_free) begin
            out_valid  <= 1'b1;
            sample_out <= y_sat[SAMPLE_BITS-1:0];
            clipped    <= clip_w | y_clip;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### design/iir_dfz2_checker.sv
// ----------------------------------------------------------------------------
// iir_dfz2_checker
// port-level checks of the z2 iir filter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "iir_direct_form_z2_filter_macros.svh"

module iir_dfz2_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             pready,
  input wire logic                             in_valid,
  input wire logic                             in_stall,
  input wire logic [iir_dfz2_pkg::CMD_W-1:0]   command,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic [SAMPLE_BITS-1:0]           sample_out,
  input wire logic                             clipped
);

  logic in_acc;

  assign in_acc = in_valid & ~in_stall;

  // a held result word keeps its payload
  `DFZ2_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
                    out_valid && $stable(sample_out) && $stable(clipped))

  // an accepted sample word closes the input behind it
  `DFZ2_ASSERT_NEXT(a_busy_after_sample, clk, rst,
                    in_acc && (command == iir_dfz2_pkg::CMD_FILTER), in_stall)

  // coefficient and unused words never produce a result
  `DFZ2_ASSERT_NEXT(a_no_result_coef, clk, rst,
                    in_acc && (command != iir_dfz2_pkg::CMD_FILTER) && !out_valid,
                    !out_valid)

  // a new result only appears at the end of sample work
  `DFZ2_ASSERT_SAME(a_result_from_work, clk, rst, $rose(out_valid),
                    $past(in_stall) && pready)

endmodule

bind iir_direct_form_z2_filter iir_dfz2_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_dfz2_checker (
  .clk        (clk),
  .rst        (rst),
  .pready     (pready),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .command    (command),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .sample_out (sample_out),
  .clipped    (clipped)
);

`default_nettype wire
